/* hw/rtl/aic_pkg.sv */
// Shared types and constants of the ASCII infix calculator.
`timescale 1ns / 1ps

package aic_pkg;

  // Longest operand in decimal digits; a further digit marks the line malformed.
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ACC_W      = 27;
  localparam int unsigned VAL_W      = 32;
  // One restoring step per quotient bit.
  localparam int unsigned DIV_STEPS  = ACC_W;
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DIVZERO = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic parse;     // take one byte into the parser
    logic eval;      // evaluate the parsed line
    logic div_step;  // one restoring division step
    logic div_last;  // final division step, capture the quotient
    logic load_out;  // move the result to the output register, restart parser
  } aic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic malformed;
    logic div_zero;
    logic is_div;
  } aic_stat_t;

endpackage

/* hw/rtl/ascii_infix_calculator.sv */
// Top level of the ASCII infix calculator.
`timescale 1ns / 1ps

// Parses "number operator number" from a stream of ASCII bytes, one byte per
// request, and returns one result request on the byte marked tlast. Ordinary
// bytes are taken at one per cycle. After the last byte of a line the input is
// held while the controller evaluates and loads the result, and for divide also
// while a restoring divider produces one of the 27 quotient bits per cycle; a
// result not yet taken by the sink holds the input longer. The output register
// lets the next line stream in while a result is pending.

module ascii_infix_calculator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] value, [58:32] left_operand, [85:59] right_operand, [87:86] operator_code
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] status
);

  aic_pkg::aic_cmd_t          cmd;
  aic_pkg::aic_stat_t         stat;
  logic [aic_pkg::VAL_W-1:0]  value;
  logic [aic_pkg::ACC_W-1:0]  left_operand;
  logic [aic_pkg::ACC_W-1:0]  right_operand;
  logic [1:0]                 operator_code;

  aic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  aic_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .ch       (in_tdata),
    .stat     (stat),
    .value_o  (value),
    .status_o (out_tuser),
    .left_o   (left_operand),
    .right_o  (right_operand),
    .opcode_o (operator_code)
  );

  assign out_tdata = {operator_code, right_operand, left_operand, value};

endmodule

/* hw/rtl/aic_dp.sv */
// Datapath: byte parser, operand accumulators, arithmetic and output register.
`timescale 1ns / 1ps

module aic_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aic_pkg::aic_cmd_t                   cmd,
  input  logic [7:0]                          ch,
  output aic_pkg::aic_stat_t                  stat,
  output logic [aic_pkg::VAL_W-1:0]           value_o,
  output logic [1:0]                          status_o,
  output logic [aic_pkg::ACC_W-1:0]           left_o,
  output logic [aic_pkg::ACC_W-1:0]           right_o,
  output logic [1:0]                          opcode_o
);

  typedef enum logic [2:0] {
    PH_SEEK_LEFT  = 3'd0,
    PH_LEFT       = 3'd1,
    PH_SEEK_OP    = 3'd2,
    PH_SEEK_RIGHT = 3'd3,
    PH_RIGHT      = 3'd4,
    PH_DONE       = 3'd5
  } phase_t;

  localparam int unsigned AW = aic_pkg::ACC_W;
  localparam int unsigned CW = aic_pkg::CNT_W;
  localparam int unsigned VW = aic_pkg::VAL_W;

  phase_t          phase_r, phase_nxt;
  logic [AW-1:0]   left_acc_r, left_acc_nxt;
  logic [AW-1:0]   right_acc_r, right_acc_nxt;
  logic [1:0]      op_held_r, op_held_nxt;
  logic [CW-1:0]   digit_cnt_r, digit_cnt_nxt;
  logic            bad_r, bad_nxt;

  logic [AW-1:0]   rem_r, quo_r;
  logic [VW-1:0]   res_r;
  logic [1:0]      stat_r;
  logic [VW-1:0]   value_r;
  logic [1:0]      status_r;
  logic [AW-1:0]   left_out_r, right_out_r;
  logic [1:0]      opcode_r;

  logic            is_dig;
  logic            op_vld;
  logic [1:0]      op_code;
  logic [AW-1:0]   sel_acc;
  logic [CW-1:0]   cnt_base;
  logic            too_long;
  logic [AW-1:0]   acc10;
  logic [CW-1:0]   cnt_inc;

  logic            malformed;
  logic            div_zero;
  logic [VW-1:0]   eval_val;
  logic [2*AW-1:0] product;

  logic [AW:0]     shifted;
  logic [AW:0]     divisor;
  logic [AW:0]     diff;
  logic            ge;
  logic [AW-1:0]   rem_nxt, quo_nxt;

  // Character classes.
  always_comb begin
    is_dig  = ch inside {[aic_pkg::CH_ZERO:aic_pkg::CH_NINE]};
    op_vld  = 1'b1;
    op_code = aic_pkg::OP_ADD;
    case (ch)
      aic_pkg::CH_PLUS:  op_code = aic_pkg::OP_ADD;
      aic_pkg::CH_MINUS: op_code = aic_pkg::OP_SUB;
      aic_pkg::CH_STAR:  op_code = aic_pkg::OP_MUL;
      aic_pkg::CH_SLASH: op_code = aic_pkg::OP_DIV;
      default:           op_vld  = 1'b0;
    endcase
  end

  // Digit append for whichever operand the parser is on. The right operand
  // starts from an empty digit count.
  always_comb begin
    case (phase_r)
      PH_SEEK_LEFT, PH_LEFT: sel_acc = left_acc_r;
      PH_SEEK_RIGHT:         sel_acc = '0;
      default:               sel_acc = right_acc_r;
    endcase
    cnt_base = (phase_r == PH_SEEK_RIGHT) ? '0 : digit_cnt_r;
    too_long = cnt_base >= CW'(aic_pkg::MAX_DIGITS);
    acc10    = (sel_acc << 3) + (sel_acc << 1) + AW'(ch[3:0]);
    cnt_inc  = cnt_base + CW'(1);
  end

  // Parser next state.
  always_comb begin
    phase_nxt     = phase_r;
    left_acc_nxt  = left_acc_r;
    right_acc_nxt = right_acc_r;
    op_held_nxt   = op_held_r;
    digit_cnt_nxt = digit_cnt_r;
    bad_nxt       = bad_r;
    if (cmd.load_out) begin
      phase_nxt     = PH_SEEK_LEFT;
      left_acc_nxt  = '0;
      right_acc_nxt = '0;
      op_held_nxt   = aic_pkg::OP_ADD;
      digit_cnt_nxt = '0;
      bad_nxt       = 1'b0;
    end else if (cmd.parse) begin
      case (phase_r)
        PH_SEEK_LEFT, PH_LEFT: begin
          if (is_dig) begin
            phase_nxt = PH_LEFT;
            if (too_long) begin
              bad_nxt = 1'b1;
            end else begin
              left_acc_nxt  = acc10;
              digit_cnt_nxt = cnt_inc;
            end
          end else if (phase_r == PH_LEFT) begin
            // The byte that ends the left operand may itself be the operator.
            phase_nxt = op_vld ? PH_SEEK_RIGHT : PH_SEEK_OP;
            if (op_vld) begin
              op_held_nxt = op_code;
            end
          end
        end
        PH_SEEK_OP: begin
          if (op_vld) begin
            op_held_nxt = op_code;
            phase_nxt   = PH_SEEK_RIGHT;
          end
        end
        PH_SEEK_RIGHT, PH_RIGHT: begin
          if (is_dig) begin
            phase_nxt = PH_RIGHT;
            if (too_long) begin
              bad_nxt = 1'b1;
            end else begin
              right_acc_nxt = acc10;
              digit_cnt_nxt = cnt_inc;
            end
          end else if (phase_r == PH_RIGHT) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Evaluation of add, subtract and multiply; division runs in steps.
  always_comb begin
    malformed = bad_r || (phase_r != PH_RIGHT && phase_r != PH_DONE);
    div_zero  = (op_held_r == aic_pkg::OP_DIV) && (right_acc_r == '0);
    product   = (2*AW)'(left_acc_r) * (2*AW)'(right_acc_r);
    case (op_held_r)
      aic_pkg::OP_ADD: eval_val = VW'(left_acc_r) + VW'(right_acc_r);
      aic_pkg::OP_SUB: eval_val = VW'(left_acc_r) - VW'(right_acc_r);
      aic_pkg::OP_MUL: eval_val = product[VW-1:0];
      default:         eval_val = '0;
    endcase
    stat.malformed = malformed;
    stat.div_zero  = div_zero;
    stat.is_div    = op_held_r == aic_pkg::OP_DIV;
  end

  // Restoring divider: one quotient bit per step, MSB first.
  always_comb begin
    shifted = {rem_r, quo_r[AW-1]};
    divisor = {1'b0, right_acc_r};
    diff    = shifted - divisor;
    ge      = shifted >= divisor;
    rem_nxt = ge ? diff[AW-1:0] : shifted[AW-1:0];
    quo_nxt = {quo_r[AW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK_LEFT;
      left_acc_r  <= '0;
      right_acc_r <= '0;
      op_held_r   <= aic_pkg::OP_ADD;
      digit_cnt_r <= '0;
      bad_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      left_acc_r  <= left_acc_nxt;
      right_acc_r <= right_acc_nxt;
      op_held_r   <= op_held_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rem_r <= '0;
      quo_r <= left_acc_r;
      if (malformed) begin
        res_r  <= '0;
        stat_r <= aic_pkg::STAT_BAD;
      end else if (div_zero) begin
        res_r  <= '0;
        stat_r <= aic_pkg::STAT_DIVZERO;
      end else begin
        res_r  <= eval_val;
        stat_r <= aic_pkg::STAT_OK;
      end
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cmd.div_last) begin
        res_r <= VW'(quo_nxt);
      end
    end
    if (cmd.load_out) begin
      value_r     <= res_r;
      status_r    <= stat_r;
      left_out_r  <= left_acc_r;
      right_out_r <= right_acc_r;
      opcode_r    <= (phase_r >= PH_SEEK_RIGHT) ? op_held_r : aic_pkg::OP_ADD;
    end
  end

  assign value_o  = value_r;
  assign status_o = status_r;
  assign left_o   = left_out_r;
  assign right_o  = right_out_r;
  assign opcode_o = opcode_r;

endmodule

/* hw/rtl/aic_ctrl.sv */
// Controller: sequences parsing, evaluation, division and result delivery.
`timescale 1ns / 1ps

module aic_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  aic_pkg::aic_stat_t stat,
  output aic_pkg::aic_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_PARSE = 2'd0,
    ST_EVAL  = 2'd1,
    ST_DIV   = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  localparam int unsigned DW = aic_pkg::DCNT_W;

  state_t        state_r, state_nxt;
  logic [DW-1:0] div_cnt_r, div_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_acc;
  logic          out_free;

  assign in_tready  = state_r == ST_PARSE;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  // The output register can take a new result once the old one is gone.
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.parse    = in_acc;
    case (state_r)
      ST_PARSE: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval    = 1'b1;
        div_cnt_nxt = '0;
        if (!stat.malformed && stat.is_div && !stat.div_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DW'(1);
        if (div_cnt_r == DW'(aic_pkg::DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_PARSE;
        end
      end
      default: state_nxt = ST_PARSE;
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PARSE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_eval_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("evaluation started without a last byte");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && div_cnt_r == DW'(aic_pkg::DIV_STEPS - 1) |=> state_r == ST_DONE)
    else $error("division did not finish after its last step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && state_r == ST_PARSE)
    else $error("result load did not raise valid and restart parsing");

endmodule

/* verif/aic_calc_checker.sv */
// Checker for the ASCII infix calculator: predicts each line's result and compares it.
`timescale 1ns / 1ps

module aic_calc_checker
  import aic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    P_SEEK_LEFT,
    P_LEFT_DIGITS,
    P_SEEK_OP,
    P_SEEK_RIGHT,
    P_RIGHT_DIGITS,
    P_IGNORE_REST
  } parse_phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic [ACC_W-1:0] lhs;
    logic [ACC_W-1:0] rhs;
    logic [1:0]       op;
  } calc_answer_t;

  parse_phase_t     phase;
  logic [ACC_W-1:0] lhs_acc;
  logic [ACC_W-1:0] rhs_acc;
  logic [1:0]       op_held;
  logic [3:0]       digit_cnt;
  logic             too_long;

  calc_answer_t pending_answers[$];
  calc_answer_t want;
  calc_answer_t got;
  int           errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_parser();
    phase     = P_SEEK_LEFT;
    lhs_acc   = '0;
    rhs_acc   = '0;
    op_held   = OP_ADD;
    digit_cnt = '0;
    too_long  = 1'b0;
  endtask

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Digits past the limit are dropped, but the line is marked malformed.
  task automatic take_digit(inout logic [ACC_W-1:0] acc, input logic [7:0] c);
    if (digit_cnt >= MAX_DIGITS) begin
      too_long = 1'b1;
    end else begin
      digit_cnt++;
      acc = ACC_W'(acc * 27'd10 + ACC_W'(c - CH_ZERO));
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (phase)
      P_SEEK_LEFT: begin
        if (is_digit(c)) begin
          phase = P_LEFT_DIGITS;
          take_digit(lhs_acc, c);
        end
      end
      P_LEFT_DIGITS: begin
        if (is_digit(c)) take_digit(lhs_acc, c);
        else phase = P_SEEK_OP;
      end
      P_SEEK_RIGHT: begin
        if (is_digit(c)) begin
          phase     = P_RIGHT_DIGITS;
          digit_cnt = '0;
          take_digit(rhs_acc, c);
        end
      end
      P_RIGHT_DIGITS: begin
        if (is_digit(c)) take_digit(rhs_acc, c);
        else phase = P_IGNORE_REST;
      end
      default: ;
    endcase
    // The byte that ends the left number may itself be the operator.
    if (phase == P_SEEK_OP) begin
      case (c)
        CH_PLUS:  begin op_held = OP_ADD; phase = P_SEEK_RIGHT; end
        CH_MINUS: begin op_held = OP_SUB; phase = P_SEEK_RIGHT; end
        CH_STAR:  begin op_held = OP_MUL; phase = P_SEEK_RIGHT; end
        CH_SLASH: begin op_held = OP_DIV; phase = P_SEEK_RIGHT; end
        default: ;
      endcase
    end
  endtask

  task automatic close_line(output calc_answer_t a);
    logic [63:0] prod;
    a.value  = '0;
    a.status = STAT_OK;
    a.lhs    = lhs_acc;
    a.rhs    = rhs_acc;
    a.op     = (phase >= P_SEEK_RIGHT) ? op_held : OP_ADD;
    // A malformed line wins over a zero divisor.
    if (too_long || phase < P_RIGHT_DIGITS) begin
      a.status = STAT_BAD;
    end else begin
      case (op_held)
        OP_ADD: a.value = VAL_W'(lhs_acc) + VAL_W'(rhs_acc);
        OP_SUB: a.value = VAL_W'(lhs_acc) - VAL_W'(rhs_acc);
        OP_MUL: begin
          prod    = 64'(lhs_acc) * 64'(rhs_acc);
          a.value = prod[VAL_W-1:0];
        end
        default: begin
          if (rhs_acc == '0) a.status = STAT_DIVZERO;
          else a.value = VAL_W'(lhs_acc / rhs_acc);
        end
      endcase
    end
    clear_parser();
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      pending_answers.delete();
      pending <= 0;
    end else begin
      // Results are checked before the same edge's input can add an expectation.
      if (out_tvalid && out_tready) begin
        got.value  = out_tdata[31:0];
        got.lhs    = out_tdata[58:32];
        got.rhs    = out_tdata[85:59];
        got.op     = out_tdata[87:86];
        got.status = out_tuser;
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result request, expected none, actual value %0h status %0h",
                   $time, got.value, got.status);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.value !== want.value) report("value", want.value, got.value);
          if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
          if (got.lhs !== want.lhs) report("left_operand", 32'(want.lhs), 32'(got.lhs));
          if (got.rhs !== want.rhs) report("right_operand", 32'(want.rhs), 32'(got.rhs));
          if (got.op !== want.op) report("operator_code", 32'(want.op), 32'(got.op));
        end
      end
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata);
        if (in_tlast) begin
          close_line(want);
          pending_answers.push_back(want);
        end
      end
      pending <= pending_answers.size();
    end
    fail_count <= errors;
  end

endmodule

/* verif/ascii_infix_calculator_tb.sv */
// Testbench top for the ASCII infix calculator: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module ascii_infix_calculator_tb;
  import aic_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int BYTE_TARGET = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;

  logic [7:0] line_q[$];
  logic [7:0] op_chars[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  int         bytes_sent = 0;
  bit         burst = 1'b0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         calm_cycles = 0;

  always #1 clk = ~clk;

  ascii_infix_calculator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  aic_calc_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // A byte that is never a digit, and never an operator unless allowed.
  function automatic logic [7:0] rand_filler(bit allow_op);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'h20 : 8'($urandom_range(0, 255));
    end while ((c >= CH_ZERO && c <= CH_NINE) ||
               (!allow_op && (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                              c == CH_SLASH)));
    return c;
  endfunction

  function automatic int digit_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
  endfunction

  task automatic put_text(input string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic is_last);
    int gap;
    gap = (burst || $urandom_range(0, 9) > 2) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    bytes_sent += line_q.size();
    line_q.delete();
  endtask

  // The pending count is registered behind the handshakes, so look after the next edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_expression();
    int op;
    op = $urandom_range(0, 3);
    repeat ($urandom_range(0, 2)) line_q.push_back(rand_filler(1'b1));
    repeat (digit_len()) line_q.push_back(rand_digit());
    repeat ($urandom_range(0, 2)) line_q.push_back(rand_filler(1'b0));
    // Digits between the left number and the operator are skipped.
    if ($urandom_range(0, 5) == 0) begin
      line_q.push_back(8'h20);
      line_q.push_back(rand_digit());
    end
    line_q.push_back(op_chars[op]);
    repeat ($urandom_range(0, 2)) line_q.push_back(rand_filler(1'b1));
    if (op_chars[op] == CH_SLASH && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(CH_ZERO);
    end else begin
      repeat (digit_len()) line_q.push_back(rand_digit());
    end
    repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_garbage();
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 9);
      if (r < 4) line_q.push_back(rand_digit());
      else if (r < 6) line_q.push_back(op_chars[$urandom_range(0, 3)]);
      else line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (calm_cycles > 0) calm_cycles--;
    else if ($urandom_range(0, 499) == 0) calm_cycles = $urandom_range(50, 200);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (calm_cycles == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    put_text("9/0");
    send_line();
    put_text("5*6");
    send_line();
    // Noise bytes at both ends of the code range and a leading sign.
    line_q.push_back(8'hFF);
    put_text("-7-8");
    line_q.push_back(8'h00);
    send_line();
    // Missing right operand after a divide: malformed, not a zero divisor.
    put_text("4/");
    send_line();
    put_text("123456789+1");
    send_line();
    wait_drained();

    while (bytes_sent < BYTE_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) build_expression();
      else build_garbage();
      send_line();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
